// ----- sv/upi_pkg.sv -----
`default_nettype none
package upi_pkg;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_MOVE     = 2'd1,
    OP_STOP     = 2'd2,
    OP_STATUS   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_H,
    ST_DIV,
    ST_FIN
  } state_t;

  // One table entry: pose and held speeds.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        angle;
    logic signed [15:0] spd;
    logic signed [15:0] rate;
  } pose_t;

  localparam int unsigned CORDIC_MAX = 24;
  localparam logic [31:0] GAIN_Q30   = 32'd652032874;
  localparam logic [31:0] TURN_RECIP = 32'd10937044;
  localparam logic [31:0] POS_HALF   = 32'd2097152000;
  localparam int unsigned POS_SHIFT  = 22;
  localparam int unsigned DIV_NUM_W  = 41;
  // 2^20 = 1048 * 1000 + 576
  localparam int unsigned DIV_SPLIT  = 20;
  localparam logic [10:0] DIV_WHOLE  = 11'd1048;
  localparam logic [9:0]  DIV_FOLD   = 10'd576;
  // ceil(2^41 / 1000), exact for dividends below 2^31
  localparam logic [31:0] DIV_RECIP  = 32'd2199023256;
  localparam int unsigned DIV_RECIP_SHIFT = 41;

  // arctan(2^-i) with 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/upi_div1000.sv -----
`default_nettype none
// Divide by 1000: fold the high part of the dividend down with
// 2^20 = 1048 * 1000 + 576, then divide the small term by a reciprocal multiply.
module upi_div1000 (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [upi_pkg::DIV_NUM_W-1:0]   num,
  output logic                                 done,
  output logic [31:0]                          quo
);

  localparam int unsigned HW = upi_pkg::DIV_NUM_W - upi_pkg::DIV_SPLIT;

  logic [HW-1:0]                 hi;
  logic [upi_pkg::DIV_SPLIT-1:0] lo;
  logic [30:0] fold_sum;
  logic [31:0] whole;
  logic [30:0] fold_q;
  logic [31:0] whole_q;
  logic        step_q;
  logic [63:0] recip_prod;

  assign hi         = num[upi_pkg::DIV_NUM_W-1:upi_pkg::DIV_SPLIT];
  assign lo         = num[upi_pkg::DIV_SPLIT-1:0];
  assign fold_sum   = 31'(hi) * 31'(upi_pkg::DIV_FOLD) + 31'(lo);
  assign whole      = 32'(hi) * 32'(upi_pkg::DIV_WHOLE);
  assign recip_prod = 64'(fold_q) * 64'(upi_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q <= 1'b0;
      done   <= 1'b0;
    end else begin
      step_q <= start;
      done   <= step_q;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      fold_q  <= fold_sum;
      whole_q <= whole;
    end
    if (step_q) begin
      quo <= whole_q + 32'(recip_prod[63:upi_pkg::DIV_RECIP_SHIFT]);
    end
  end

endmodule
`default_nettype wire

// ----- sv/unicycle_pose_integrator_table.sv -----
`default_nettype none
// A register, stop or status item passes through load and finish; a move passes through load,
// the CORDIC iterations, three passes of the shared 32x32 multiplier, a divide by 1000 and
// finish. One item is in work at a time; the next item is accepted while the previous
// result still waits in the output register. Finish holds while that register is full.
// Reset clears presence flags; an absent entry reads as an all-zero pose.
module unicycle_pose_integrator_table #(
  parameter int unsigned UNITS        = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [3:0]         unit,
  input  wire logic signed [15:0] linear_speed,
  input  wire logic signed [15:0] turn_rate,
  input  wire logic [15:0]        duration_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    online,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [15:0]             heading,
  output logic signed [15:0]      held_linear,
  output logic signed [15:0]      held_turn
);

  localparam int unsigned AW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int unsigned STEPS =
    (CORDIC_STEPS > upi_pkg::CORDIC_MAX) ? upi_pkg::CORDIC_MAX : CORDIC_STEPS;

  upi_pkg::state_t state, state_next;

  // Pose table: one synchronous memory, presence held in flip-flops.
  upi_pkg::pose_t mem [UNITS];
  upi_pkg::pose_t rd_q;
  logic [UNITS-1:0] present;

  // Item under work
  upi_pkg::op_t   cur_op;
  logic [AW-1:0]  cur_addr;
  logic           cur_rng;
  logic signed [15:0] cur_spd;
  logic signed [15:0] cur_rate;
  logic [15:0]    cur_dur;
  upi_pkg::pose_t work;
  logic           work_pres;
  upi_pkg::pose_t load_entry;
  logic           load_pres;

  logic [8:0]     unit_ext;
  logic [AW-1:0]  in_addr;
  logic           in_rng;
  logic           accept;

  // CORDIC
  logic signed [33:0] cx, cy, cz;
  logic [4:0]         it;
  logic               flip;
  logic               last_step;
  logic signed [33:0] xs, ys, at;
  logic [15:0]        hr;
  logic signed [31:0] zi;
  logic signed [33:0] cos_v, sin_v;
  logic [31:0]        mag_c, mag_s;

  // Products
  logic signed [32:0] sd_lin, sd_rot;
  logic [31:0]        mag_lin, mag_rot;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_res;
  logic [63:0]        prod_x, prod_y, prod_h;
  logic               sgn_x, sgn_y;
  logic [63:0]        rnd_x, rnd_y, rnd_h;
  logic [15:0]        dh;

  // Dividers
  logic        div_start;
  logic        dx_done, dy_done;
  logic [31:0] qx, qy;
  logic signed [33:0] sum_x, sum_y;
  logic signed [31:0] new_x, new_y;

  assign unit_ext = 9'(unit);
  assign in_addr  = unit_ext[AW-1:0];
  assign in_rng   = unit_ext < 9'(UNITS);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= upi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      upi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = upi_pkg::ST_LOAD;
      end
      upi_pkg::ST_LOAD: begin
        if (cur_rng && cur_op == upi_pkg::OP_MOVE) state_next = upi_pkg::ST_ROT;
        else state_next = upi_pkg::ST_FIN;
      end
      upi_pkg::ST_ROT: begin
        if (last_step) state_next = upi_pkg::ST_MUL_X;
      end
      upi_pkg::ST_MUL_X: state_next = upi_pkg::ST_MUL_Y;
      upi_pkg::ST_MUL_Y: state_next = upi_pkg::ST_MUL_H;
      upi_pkg::ST_MUL_H: begin
        div_start  = 1'b1;
        state_next = upi_pkg::ST_DIV;
      end
      upi_pkg::ST_DIV: begin
        if (dx_done) state_next = upi_pkg::ST_FIN;
      end
      upi_pkg::ST_FIN: begin
        if (!out_valid || out_ready) state_next = upi_pkg::ST_IDLE;
      end
      default: state_next = upi_pkg::ST_IDLE;
    endcase
  end

  // Memory read on accept; write back as the result leaves.
  always_ff @(posedge clk) begin
    if (accept) rd_q <= mem[in_addr];
    if (state == upi_pkg::ST_FIN && (!out_valid || out_ready) && cur_rng) begin
      mem[cur_addr] <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (state == upi_pkg::ST_FIN && (!out_valid || out_ready) && cur_rng) begin
      present[cur_addr] <= work_pres;
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op   <= upi_pkg::op_t'(operation);
      cur_addr <= in_addr;
      cur_rng  <= in_rng;
      cur_spd  <= linear_speed;
      cur_rate <= turn_rate;
      cur_dur  <= duration_ms;
    end
  end

  // Entry as modified by the operation; an absent entry reads as zero.
  always_comb begin
    load_entry = present[cur_addr] ? rd_q : '0;
    load_pres  = present[cur_addr];
    unique case (cur_op)
      upi_pkg::OP_REGISTER: load_pres = 1'b1;
      upi_pkg::OP_MOVE: begin
        load_pres       = 1'b1;
        load_entry.spd  = cur_spd;
        load_entry.rate = cur_rate;
      end
      upi_pkg::OP_STOP: begin
        if (present[cur_addr]) begin
          load_entry.spd  = '0;
          load_entry.rate = '0;
        end
      end
      default: ;
    endcase
  end

  // CORDIC step logic
  assign last_step = it == 5'(STEPS - 1);
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign at = 34'({2'b00, upi_pkg::atan_turn(it)});
  assign hr = (work.angle[15] ^ work.angle[14]) ? (work.angle ^ 16'h8000) : work.angle;
  assign zi = {hr, 16'h0000};
  assign cos_v = flip ? -cx : cx;
  assign sin_v = flip ? -cy : cy;
  assign mag_c = cos_v[33] ? 32'(-cos_v) : cos_v[31:0];
  assign mag_s = sin_v[33] ? 32'(-sin_v) : sin_v[31:0];
  assign mag_lin = sd_lin[32] ? 32'(-sd_lin) : sd_lin[31:0];
  assign mag_rot = sd_rot[32] ? 32'(-sd_rot) : sd_rot[31:0];

  // One shared multiplier, operands chosen by state
  always_comb begin
    mul_a = mag_lin;
    mul_b = mag_c;
    unique case (state)
      upi_pkg::ST_MUL_Y: mul_b = mag_s;
      upi_pkg::ST_MUL_H: begin
        mul_a = mag_rot;
        mul_b = upi_pkg::TURN_RECIP;
      end
      default: mul_b = mag_c;
    endcase
  end
  assign mul_res = 64'(mul_a) * 64'(mul_b);

  // Round to nearest, ties away: add half divisor to magnitudes.
  assign rnd_x = prod_x + 64'(upi_pkg::POS_HALF);
  assign rnd_y = prod_y + 64'(upi_pkg::POS_HALF);
  assign rnd_h = prod_h + 64'h0000_0000_8000_0000;
  assign dh    = sd_rot[32] ? 16'(-rnd_h[47:32]) : rnd_h[47:32];

  assign sum_x = 34'(work.px) + (sgn_x ? -34'(qx) : 34'(qx));
  assign sum_y = 34'(work.py) + (sgn_y ? -34'(qy) : 34'(qy));
  assign new_x = (sum_x > 34'sd2147483647) ? 32'sh7fffffff :
                 (sum_x < -34'sd2147483648) ? 32'sh80000000 : sum_x[31:0];
  assign new_y = (sum_y > 34'sd2147483647) ? 32'sh7fffffff :
                 (sum_y < -34'sd2147483648) ? 32'sh80000000 : sum_y[31:0];

  upi_div1000 u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rnd_x[upi_pkg::POS_SHIFT + upi_pkg::DIV_NUM_W - 1:upi_pkg::POS_SHIFT]),
    .done  (dx_done),
    .quo   (qx)
  );

  upi_div1000 u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rnd_y[upi_pkg::POS_SHIFT + upi_pkg::DIV_NUM_W - 1:upi_pkg::POS_SHIFT]),
    .done  (dy_done),
    .quo   (qy)
  );

  // Datapath: read, modify, hold the new entry in work
  always_ff @(posedge clk) begin
    unique case (state)
      upi_pkg::ST_LOAD: begin
        work      <= load_entry;
        work_pres <= load_pres;
        sd_lin    <= 33'(cur_spd) * 33'($signed({1'b0, cur_dur}));
        sd_rot    <= 33'(cur_rate) * 33'($signed({1'b0, cur_dur}));
        it <= '0;
        cx <= 34'(upi_pkg::GAIN_Q30);
        cy <= '0;
      end
      upi_pkg::ST_ROT: begin
        if (it == 5'd0) begin
          // first pass seeds z from the stored heading
          flip <= work.angle[15] ^ work.angle[14];
          if (zi >= 0) begin
            cx <= cx - ys; cy <= cy + xs; cz <= 34'(zi) - at;
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= 34'(zi) + at;
          end
        end else if (cz >= 0) begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - at;
        end else begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + at;
        end
        it <= it + 5'd1;
      end
      upi_pkg::ST_MUL_X: begin
        prod_x <= mul_res;
        sgn_x  <= sd_lin[32] ^ cos_v[33];
      end
      upi_pkg::ST_MUL_Y: begin
        prod_y <= mul_res;
        sgn_y  <= sd_lin[32] ^ sin_v[33];
      end
      upi_pkg::ST_MUL_H: prod_h <= mul_res;
      upi_pkg::ST_DIV: begin
        if (dx_done) begin
          work <= '{new_x, new_y, 16'(work.angle + dh), work.spd, work.rate};
        end
      end
      default: ;
    endcase
  end

  // Output register: frees the work path while the result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == upi_pkg::ST_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == upi_pkg::ST_FIN && (!out_valid || out_ready)) begin
      // unit beyond the table: everything reads zero
      online      <= cur_rng & work_pres;
      pos_x       <= cur_rng ? work.px : '0;
      pos_y       <= cur_rng ? work.py : '0;
      heading     <= cur_rng ? work.angle : '0;
      held_linear <= cur_rng ? work.spd : '0;
      held_turn   <= cur_rng ? work.rate : '0;
    end
  end

  // Both divide lanes run in lock step.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) dx_done == dy_done)
    else $error("divider lanes out of step");

  // An accepted item blocks further input in the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst) accept |=> !in_ready)
    else $error("second item accepted while one is in work");

  // An absent unit reports an all-zero pose.
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !online) |-> (pos_x == 0 && pos_y == 0 && heading == 0 &&
                                held_linear == 0 && held_turn == 0))
    else $error("absent unit with nonzero state");

endmodule
`default_nettype wire

// ----- bench/pose_table_checker.sv -----
`default_nettype none
module pose_table_checker #(
  parameter int unsigned UNITS        = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [3:0]         unit,
  input  wire logic signed [15:0] linear_speed,
  input  wire logic signed [15:0] turn_rate,
  input  wire logic [15:0]        duration_ms,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               online,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic [15:0]        heading,
  input  wire logic signed [15:0] held_linear,
  input  wire logic signed [15:0] held_turn,
  output int                      errors,
  output int                      pending
);

  typedef struct {
    logic               on;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        h;
    logic signed [15:0] lin;
    logic signed [15:0] rot;
  } unit_view_t;

  logic        on_tab  [UNITS];
  logic signed [31:0] x_tab [UNITS];
  logic signed [31:0] y_tab [UNITS];
  logic [15:0] h_tab   [UNITS];
  logic signed [15:0] lin_tab [UNITS];
  logic signed [15:0] rot_tab [UNITS];
  unit_view_t  expected_views[$];

  localparam longint ARCTAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rotate the gain vector to the heading; returns cos and sin in Q2.30.
  task automatic rotate_heading(input logic [15:0] hd, output longint c, output longint s);
    logic        flip;
    logic [15:0] r;
    longint      z, xx, yy, xs, ys;
    int          n;
    flip = (hd >= 16'h4000 && hd < 16'hC000);
    r    = flip ? (hd ^ 16'h8000) : hd;
    z    = longint'($signed(r)) * 65536;
    xx   = upi_pkg::GAIN_Q30;
    yy   = 0;
    n    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      xs = xx >>> i;
      ys = yy >>> i;
      if (z >= 0) begin
        xx -= ys; yy += xs; z -= ARCTAN[i];
      end else begin
        xx += ys; yy -= xs; z += ARCTAN[i];
      end
    end
    c = flip ? -xx : xx;
    s = flip ? -yy : yy;
  endtask

  task automatic integrate_item();
    unit_view_t v;
    longint     c, s, spd, rt, d, dh;
    int         u;
    u = unit;
    v = '{1'b0, 0, 0, 0, 0, 0};
    if (u < UNITS) begin
      unique case (upi_pkg::op_t'(operation))
        upi_pkg::OP_REGISTER: begin
          if (!on_tab[u]) begin
            on_tab[u] = 1'b1; x_tab[u] = 0; y_tab[u] = 0; h_tab[u] = 0;
            lin_tab[u] = 0; rot_tab[u] = 0;
          end
        end
        upi_pkg::OP_MOVE: begin
          spd = linear_speed;
          rt  = turn_rate;
          d   = duration_ms;
          if (!on_tab[u]) begin
            on_tab[u] = 1'b1; x_tab[u] = 0; y_tab[u] = 0; h_tab[u] = 0;
          end
          lin_tab[u] = linear_speed;
          rot_tab[u] = turn_rate;
          rotate_heading(h_tab[u], c, s);
          x_tab[u] = clamp32(longint'(x_tab[u]) + round_div(spd * c * d, 64'd4194304000));
          y_tab[u] = clamp32(longint'(y_tab[u]) + round_div(spd * s * d, 64'd4194304000));
          dh = round_div(rt * d * upi_pkg::TURN_RECIP, 64'd4294967296);
          h_tab[u] = h_tab[u] + dh[15:0];
        end
        upi_pkg::OP_STOP: begin
          if (on_tab[u]) begin
            lin_tab[u] = 0; rot_tab[u] = 0;
          end
        end
        default: ;
      endcase
      v = '{on_tab[u], x_tab[u], y_tab[u], h_tab[u], lin_tab[u], rot_tab[u]};
    end
    expected_views.push_back(v);
  endtask

  task automatic compare_result();
    unit_view_t e;
    if (expected_views.size() == 0) begin
      $error("result with no item outstanding");
      errors++;
      return;
    end
    e = expected_views.pop_front();
    if (online !== e.on) begin
      $error("online: expected %0d got %0d", e.on, online); errors++;
    end
    if (pos_x !== e.x) begin
      $error("pos_x: expected %0d got %0d", e.x, pos_x); errors++;
    end
    if (pos_y !== e.y) begin
      $error("pos_y: expected %0d got %0d", e.y, pos_y); errors++;
    end
    if (heading !== e.h) begin
      $error("heading: expected %0d got %0d", e.h, heading); errors++;
    end
    if (held_linear !== e.lin) begin
      $error("held_linear: expected %0d got %0d", e.lin, held_linear); errors++;
    end
    if (held_turn !== e.rot) begin
      $error("held_turn: expected %0d got %0d", e.rot, held_turn); errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < UNITS; i++) begin
        on_tab[i] = 0; x_tab[i] = 0; y_tab[i] = 0; h_tab[i] = 0;
        lin_tab[i] = 0; rot_tab[i] = 0;
      end
      expected_views.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) integrate_item();
      pending <= expected_views.size();
    end
  end

endmodule
`default_nettype wire

// ----- bench/unicycle_pose_integrator_table_tb.sv -----
`default_nettype none
module unicycle_pose_integrator_table_tb;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = upi_pkg::OP_STATUS;
  logic [3:0]         unit = '0;
  logic signed [15:0] linear_speed = '0;
  logic signed [15:0] turn_rate = '0;
  logic [15:0]        duration_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               online;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0]        heading;
  logic signed [15:0] held_linear, held_turn;
  int                 errors, pending;

  // Idle percentages per side; the hold-off flag parks the receiver outright.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  int  cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  unicycle_pose_integrator_table dut (
    .clk, .rst, .in_valid, .in_ready, .operation, .unit, .linear_speed, .turn_rate,
    .duration_ms, .out_valid, .out_ready, .online, .pos_x, .pos_y, .heading,
    .held_linear, .held_turn
  );

  pose_table_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .operation, .unit, .linear_speed, .turn_rate,
    .duration_ms, .out_valid, .out_ready, .online, .pos_x, .pos_y, .heading,
    .held_linear, .held_turn, .errors, .pending
  );

  // Receiver: stall at random unless the hold-off is on.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one item, idle first at random, and hold it until accepted.
  // Valid stays high after acceptance until the next idle cycle or drain.
  task automatic send_item(input upi_pkg::op_t op, input logic [3:0] u,
                           input logic [15:0] spd, input logic [15:0] rt,
                           input logic [15:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    unit         <= u;
    linear_speed <= spd;
    turn_rate    <= rt;
    duration_ms  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly moves and status checks on random units, with mostly short durations
  // so positions build up without always saturating.
  task automatic random_item();
    int           sel;
    upi_pkg::op_t op;
    logic [15:0]  d;
    sel = $urandom_range(99);
    op  = (sel < 45) ? upi_pkg::OP_MOVE : (sel < 65) ? upi_pkg::OP_STATUS :
          (sel < 80) ? upi_pkg::OP_STOP : upi_pkg::OP_REGISTER;
    d   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
    send_item(op, 4'($urandom), 16'($urandom), 16'($urandom), d);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: absent unit reads, register, extremes of speed, rate and duration.
    send_item(upi_pkg::OP_STATUS, 4'd0, 16'h0, 16'h0, 16'h0);
    send_item(upi_pkg::OP_STOP, 4'd1, 16'h0, 16'h0, 16'h0);
    send_item(upi_pkg::OP_REGISTER, 4'd1, 16'h0, 16'h0, 16'h0);
    send_item(upi_pkg::OP_REGISTER, 4'd1, 16'h0, 16'h0, 16'h0);
    send_item(upi_pkg::OP_MOVE, 4'd1, 16'h7fff, 16'h7fff, 16'hffff);
    send_item(upi_pkg::OP_MOVE, 4'd1, 16'h8000, 16'h8000, 16'hffff);
    send_item(upi_pkg::OP_MOVE, 4'd2, 16'h0100, 16'h1000, 16'd1000);
    send_item(upi_pkg::OP_MOVE, 4'd2, 16'hff00, 16'h0000, 16'd0);
    send_item(upi_pkg::OP_MOVE, 4'd15, 16'h7fff, 16'h0000, 16'hffff);
    repeat (6) send_item(upi_pkg::OP_MOVE, 4'd15, 16'h7fff, 16'h0000, 16'hffff);
    send_item(upi_pkg::OP_MOVE, 4'd14, 16'h8000, 16'h3244, 16'hffff);
    repeat (6) send_item(upi_pkg::OP_MOVE, 4'd14, 16'h8000, 16'h0000, 16'hffff);
    send_item(upi_pkg::OP_STOP, 4'd14, 16'hffff, 16'hffff, 16'hffff);
    send_item(upi_pkg::OP_STATUS, 4'd15, 16'h0, 16'h0, 16'h0);
    drain();

    // Phase one: sender idles a little, receiver a lot.
    send_idle_pct = 21; recv_idle_pct = 64;
    repeat (300) random_item();

    // Hold the receiver off long while the sender keeps offering items.
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
      repeat (6) random_item();
    join
    drain();

    send_idle_pct = 64; recv_idle_pct = 21;
    repeat (300) random_item();
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (300) random_item();

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
